// ===== design/fhtc_pkg.sv =====
// package for the fiber hit time clusterer
// holds widths, depth, command codes, queue and state types; no dependencies
package fhtc_pkg;
	localparam int HitDepth = 64;
	localparam int IdxW = $clog2(HitDepth);
	localparam int CntW = $clog2(HitDepth + 1);
	localparam logic [31:0] ThreshReset = 32'd1240;
	localparam logic [23:0] WindowReset = 24'd3000;
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_EOE = 1'b1;
	localparam logic CFG_THRESH = 1'b0;
	localparam logic CFG_WINDOW = 1'b1;

	typedef struct packed {
		logic [9:0] fiber;
		logic [47:0] time_ps;
		logic [31:0] energy;
		logic [30:0] track;
		logic [30:0] parent;
		logic [31:0] particle;
	} hit_t;

	typedef struct packed {
		logic eoe;
		hit_t hit;
	} qent_t;

	typedef enum logic [2:0] {
		ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_GRP_RD, ST_GRP_ACC, ST_EMIT
	} bstate_t;
endpackage

// ===== design/fhtc_front.sv =====
// front part: filters add commands by charge and threshold, passes kept hits
// and end-of-event marks to the queue; uses fhtc_pkg
module fhtc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic charged,
	input fhtc_pkg::hit_t hit,
	input logic [31:0] thresh,
	output logic q_valid,
	input logic q_ready,
	output fhtc_pkg::qent_t q_data
);
	import fhtc_pkg::*;
	logic keep;
	logic valid_q;
	qent_t data_q;
	assign keep = (cmd == CMD_EOE) || (charged && (hit.energy >= thresh));
	assign in_ready = !valid_q || q_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid && keep;
	end
	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q.eoe <= (cmd == CMD_EOE);
			data_q.hit <= hit;
		end
	end
	assign q_valid = valid_q;
	assign q_data = data_q;
endmodule

// ===== design/fhtc_queue.sv =====
// short fifo between front and back parts; uses fhtc_pkg
module fhtc_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input fhtc_pkg::qent_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output fhtc_pkg::qent_t rd_data
);
	import fhtc_pkg::*;
	qent_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;
	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

// ===== design/fhtc_back.sv =====
// back part: stores hits, insertion-sorts on end of event, groups and emits
// uses fhtc_pkg; one store memory with a registered read port
module fhtc_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input fhtc_pkg::qent_t q_data,
	input logic [23:0] window,
	output logic out_valid,
	input logic out_ready,
	output logic [5:0] o_index,
	output fhtc_pkg::hit_t o_hit,
	output logic [37:0] o_sum,
	output logic o_ovf,
	output logic o_last
);
	import fhtc_pkg::*;
	hit_t store_q [HitDepth];
	logic [IdxW-1:0] ord_q [HitDepth];
	bstate_t state_q, state_d;
	logic [CntW-1:0] cnt_q, i_q, j_q, pos_q;
	logic drop_q;
	logic [IdxW-1:0] rd_addr;
	logic rd_en;
	hit_t rd_q, cur_q, top_q, first_q;
	logic [37:0] sum_q;
	logic [48:0] close_q;
	logic [5:0] emit_q;
	logic last_q, oval_q, open_q;
	logic sorts_first, in_grp, grp_take, grp_end, emit_go;
	logic [IdxW-1:0] i_idx, ordr_q, ord_wa, ord_wd, ord_ra;
	logic ord_we, ord_re, ord_fwd;

	assign i_idx = i_q[IdxW-1:0];
	assign sorts_first = (cur_q.fiber != rd_q.fiber) ? (cur_q.fiber < rd_q.fiber)
		: (cur_q.time_ps < rd_q.time_ps);
	assign in_grp = (rd_q.fiber == first_q.fiber) && ({1'b0, rd_q.time_ps} <= close_q);
	assign grp_take = !open_q || in_grp;
	assign grp_end = !grp_take || (CntW'(pos_q + 1'b1) == cnt_q);
	assign emit_go = !oval_q || out_ready;
	assign q_ready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = ordr_q;
		ord_we = 1'b0;
		ord_wa = j_q[IdxW-1:0];
		ord_wd = i_idx;
		ord_re = 1'b0;
		ord_ra = i_idx;
		ord_fwd = 1'b0;
		case (state_q)
			ST_LOAD: if (q_valid && q_data.eoe) begin
				if (cnt_q != '0) state_d = ST_SORT_RD;
			end
			ST_SORT_RD: begin
				rd_en = 1'b1;
				if (i_q == cnt_q) begin
					state_d = ST_GRP_RD;
					ord_re = 1'b1;
					ord_ra = '0;
				end else if (j_q == '0) begin
					ord_we = 1'b1;
					ord_re = 1'b1;
					ord_fwd = (j_q == i_q);
				end else state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				state_d = ST_SORT_RD;
				ord_we = 1'b1;
				ord_re = 1'b1;
				if (sorts_first) begin
					ord_wd = ordr_q;
					ord_ra = IdxW'(j_q - 2'd2);
				end else ord_fwd = (j_q == i_q);
			end
			ST_GRP_RD: begin
				rd_en = 1'b1;
				state_d = ST_GRP_ACC;
			end
			ST_GRP_ACC: begin
				state_d = grp_end ? ST_EMIT : ST_GRP_RD;
				if (grp_take) begin
					ord_re = 1'b1;
					ord_ra = IdxW'(pos_q + 1'b1);
				end
			end
			ST_EMIT: if (emit_go)
				state_d = last_q ? ST_LOAD : ST_GRP_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && q_valid && !q_data.eoe && cnt_q < CntW'(HitDepth))
			store_q[cnt_q[IdxW-1:0]] <= q_data.hit;
		if (rd_en) rd_q <= store_q[rd_addr];
		if (state_q == ST_SORT_RD && i_q != cnt_q && j_q == i_q) cur_q <= store_q[i_idx];
		if (ord_we) ord_q[ord_wa] <= ord_wd;
		if (ord_re) ordr_q <= ord_fwd ? i_idx : ord_q[ord_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			drop_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			pos_q <= '0;
			emit_q <= '0;
			oval_q <= 1'b0;
			sum_q <= '0;
			close_q <= '0;
			last_q <= 1'b0;
			open_q <= 1'b0;
			first_q <= '0;
			top_q <= '0;
			o_index <= '0;
			o_hit <= '0;
			o_sum <= '0;
			o_ovf <= 1'b0;
			o_last <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && emit_go) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
			case (state_q)
				ST_LOAD: if (q_valid) begin
					if (q_data.eoe) begin
						i_q <= '0;
						j_q <= '0;
						pos_q <= '0;
						emit_q <= '0;
						sum_q <= '0;
						if (cnt_q == '0) drop_q <= 1'b0;
					end else if (cnt_q < CntW'(HitDepth)) cnt_q <= cnt_q + 1'b1;
					else drop_q <= 1'b1;
				end
				ST_SORT_RD: if (i_q != cnt_q && j_q == '0) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + 1'b1;
				end
				ST_SORT_CMP: begin
					if (sorts_first) j_q <= j_q - 1'b1;
					else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + 1'b1;
					end
				end
				ST_GRP_ACC: begin
					if (!open_q) begin
						open_q <= 1'b1;
						first_q <= rd_q;
						top_q <= rd_q;
						close_q <= {1'b0, rd_q.time_ps} + 49'(window);
						sum_q <= 38'(rd_q.energy);
					end else if (in_grp) begin
						sum_q <= sum_q + 38'(rd_q.energy);
						if (rd_q.track < top_q.track) top_q <= rd_q;
					end
					if (grp_take) pos_q <= pos_q + 1'b1;
					last_q <= grp_take && grp_end;
				end
				ST_EMIT: if (emit_go) begin
					o_index <= emit_q;
					o_hit <= top_q;
					o_sum <= sum_q;
					o_ovf <= drop_q;
					o_last <= last_q;
					emit_q <= emit_q + 1'b1;
					sum_q <= '0;
					open_q <= 1'b0;
					if (last_q) begin
						cnt_q <= '0;
						drop_q <= 1'b0;
						last_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
	assign out_valid = oval_q;

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && state_d == ST_LOAD) |=> cnt_q == '0)
		else $error("count not cleared after event");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !q_ready)
		else $error("queue popped while busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(HitDepth))
		else $error("count beyond depth");
endmodule

// ===== design/fiber_hit_time_clusterer.sv =====
// top level of the fiber hit time clusterer: config registers, front, queue, back
// uses fhtc_pkg, fhtc_front, fhtc_queue, fhtc_back
// hits are taken one per cycle while the front and the queue have room, and pass through the
// front register and the queue into the store; an end of event with stored hits insertion-sorts
// them (a read and a compare state per step), then reads, groups and emits, held by output stalls
// reset clears counters, flags and handshakes; the threshold returns to 1240 and the window to 3000
module fiber_hit_time_clusterer (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [191:0] s_tdata, // charged, fiber_number, hit_time, energy_deposit, track_number, parent_number, particle_code
	input logic s_tuser, // cmd
	output logic m_tvalid,
	input logic m_tready,
	output logic [199:0] m_tdata, // cluster_index, out_fiber, out_time, energy_sum, out_track, out_parent, out_particle, overflowed
	output logic m_tlast,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_wdata
);
	import fhtc_pkg::*;
	logic [31:0] thresh_q;
	logic [23:0] window_q;
	hit_t in_hit, o_hit;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	qent_t fq_data, bq_data;
	logic [5:0] o_index;
	logic [37:0] o_sum;
	logic o_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
			window_q <= WindowReset;
		end else if (cfg_we) begin
			if (cfg_index == CFG_THRESH) thresh_q <= cfg_wdata;
			if (cfg_index == CFG_WINDOW) window_q <= cfg_wdata[23:0];
		end
	end

	assign in_hit.fiber = s_tdata[10:1];
	assign in_hit.time_ps = s_tdata[58:11];
	assign in_hit.energy = s_tdata[90:59];
	assign in_hit.track = s_tdata[121:91];
	assign in_hit.parent = s_tdata[152:122];
	assign in_hit.particle = s_tdata[184:153];

	fhtc_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.cmd(s_tuser), .charged(s_tdata[0]), .hit(in_hit), .thresh(thresh_q),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));
	fhtc_queue u_queue (.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
		.wr_data(fq_data), .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data));
	fhtc_back u_back (.clk, .arst_n, .q_valid(bq_valid), .q_ready(bq_ready),
		.q_data(bq_data), .window(window_q), .out_valid(m_tvalid), .out_ready(m_tready),
		.o_index, .o_hit, .o_sum, .o_ovf, .o_last(m_tlast));

	assign m_tdata = {3'd0, o_ovf, o_hit.particle, o_hit.parent, o_hit.track, o_sum,
		o_hit.time_ps, o_hit.fiber, o_index};
endmodule

// ===== tb/testbench.sv =====
// testbench for fiber_hit_time_clusterer: drives hit and end-of-event transactions
// and checks merged hits against an in-bench cluster predictor; uses fhtc_pkg
`timescale 1ns / 100ps

class cluster_scoreboard;
	logic [31:0] thresh;
	logic [23:0] window;
	logic [9:0] h_fiber[$];
	logic [47:0] h_time[$];
	logic [31:0] h_energy[$];
	logic [30:0] h_track[$];
	logic [30:0] h_parent[$];
	logic [31:0] h_particle[$];
	logic dropped;
	logic [199:0] exp_data[$];
	logic exp_last[$];
	int errors;
	int clusters;
	int events;

	function new();
		thresh = fhtc_pkg::ThreshReset;
		window = fhtc_pkg::WindowReset;
		dropped = 1'b0;
		errors = 0;
		clusters = 0;
		events = 0;
	endfunction

	function void note_input(logic cmd, logic [191:0] d);
		int order[$];
		int n, i, j, cur, pos, top, idx;
		logic [48:0] close;
		logic [37:0] sum;
		if (cmd == fhtc_pkg::CMD_ADD) begin
			if (!d[0] || d[90:59] < thresh)
				return;
			if (h_fiber.size() >= fhtc_pkg::HitDepth) begin
				dropped = 1'b1;
				return;
			end
			h_fiber.push_back(d[10:1]);
			h_time.push_back(d[58:11]);
			h_energy.push_back(d[90:59]);
			h_track.push_back(d[121:91]);
			h_parent.push_back(d[152:122]);
			h_particle.push_back(d[184:153]);
			return;
		end
		events++;
		n = h_fiber.size();
		for (i = 0; i < n; i++) begin
			cur = i;
			j = i;
			order.insert(j, cur);
			while (j > 0 && (h_fiber[cur] < h_fiber[order[j-1]] ||
					(h_fiber[cur] == h_fiber[order[j-1]] &&
					h_time[cur] < h_time[order[j-1]]))) begin
				order[j] = order[j-1];
				order[j-1] = cur;
				j--;
			end
		end
		pos = 0;
		idx = 0;
		while (pos < n) begin
			close = {1'b0, h_time[order[pos]]} + window;
			top = order[pos];
			sum = '0;
			j = pos;
			while (j < n && h_fiber[order[j]] == h_fiber[order[pos]] &&
					{1'b0, h_time[order[j]]} <= close) begin
				sum += h_energy[order[j]];
				if (h_track[order[j]] < h_track[top])
					top = order[j];
				j++;
			end
			pos = j;
			exp_data.push_back({3'b0, dropped, h_particle[top], h_parent[top], h_track[top],
				sum, h_time[top], h_fiber[top], idx[5:0]});
			exp_last.push_back(pos >= n);
			idx++;
		end
		h_fiber.delete();
		h_time.delete();
		h_energy.delete();
		h_track.delete();
		h_parent.delete();
		h_particle.delete();
		dropped = 1'b0;
	endfunction

	function void check_result(logic [199:0] d, logic lst);
		clusters++;
		if (exp_data.size() == 0) begin
			$display("%0t unexpected result %h last %b", $time, d, lst);
			errors++;
			return;
		end
		if (d !== exp_data[0] || lst !== exp_last[0]) begin
			$display("%0t mismatch expected %h last %b actual %h last %b", $time,
				exp_data[0], exp_last[0], d, lst);
			errors++;
		end
		void'(exp_data.pop_front());
		void'(exp_last.pop_front());
	endfunction
endclass

module testbench;
	import fhtc_pkg::*;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [191:0] s_tdata; // charged, fiber_number, hit_time, energy_deposit, track, parent, particle
	logic s_tuser; // cmd
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [199:0] m_tdata; // index, fiber, time, energy_sum, track, parent, particle, overflowed
	logic m_tlast;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_wdata;

	cluster_scoreboard sb;
	int send_idle;
	int recv_stall;
	int cycles = 0;
	int hits_sent;

	fiber_hit_time_clusterer u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send(logic cmd, logic [191:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= d;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(cmd, d);
	endtask

	task automatic send_hit(logic chg, logic [9:0] f, logic [47:0] t, logic [31:0] e,
			logic [30:0] tr, logic [30:0] pa, logic [31:0] pc);
		send(CMD_ADD, {7'b0, pc, pa, tr, e, t, f, chg});
		hits_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.exp_data.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_THRESH)
			sb.thresh = v;
		else
			sb.window = v[23:0];
		@(posedge clk);
	endtask

	task automatic random_event(int nhits, int nfib);
		logic [47:0] base;
		base = $urandom_range(3) == 0 ? 48'hFFFF_FFFF_F000 : 48'({$urandom, $urandom});
		for (int i = 0; i < nhits; i++) begin
			send_hit($urandom_range(9) != 0,
				10'($urandom_range(nfib - 1) * ($urandom_range(1) ? 1 : 97)),
				$urandom_range(7) == 0 ? 48'({$urandom, $urandom})
					: 48'(base + $urandom_range(12000)),
				$urandom_range(3) == 0 ? $urandom : $urandom_range(5000),
				$urandom_range(1) ? 31'($urandom_range(7)) : 31'($urandom), 31'($urandom),
				$urandom);
		end
		if ($urandom_range(9) == 0)
			send(CMD_ADD, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		send(CMD_EOE, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
	endtask

	initial begin
		sb = new();
		hits_sent = 0;
		send_idle = 0;
		recv_stall = 0;
		s_tvalid = 1'b0;
		s_tuser = CMD_ADD;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESH;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, equal times, equal tracks, threshold edge, uncharged
		send(CMD_EOE, '1);
		send_hit(1'b1, 10'd1023, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 32'h8000_0000);
		send_hit(1'b1, 10'd1023, 48'hFFFF_FFFF_F000, 32'd1240, 31'h7FFF_FFFF, 31'd0,
			32'h7FFF_FFFF);
		send_hit(1'b1, 10'd0, 48'd0, 32'd1239, 31'd0, 31'd0, 32'd0);
		send_hit(1'b0, 10'd0, 48'd5, 32'hFFFF_FFFF, 31'd1, 31'd2, 32'd11);
		send_hit(1'b1, 10'd0, 48'd100, 32'd2000, 31'd5, 31'd1, 32'd13);
		send_hit(1'b1, 10'd0, 48'd100, 32'd3000, 31'd5, 31'd2, 32'hFFFF_FFF3);
		send_hit(1'b1, 10'd0, 48'd3100, 32'd4000, 31'd3, 31'd3, 32'd22);
		send_hit(1'b1, 10'd0, 48'd3101, 32'd5000, 31'd1, 31'd4, 32'd211);
		send_hit(1'b1, 10'd0, 48'd50, 32'd6000, 31'd9, 31'd5, 32'd2212);
		send(CMD_EOE, '0);
		drain();
		write_cfg(CFG_THRESH, 32'd0);
		write_cfg(CFG_WINDOW, 32'h00FF_FFFF);
		for (int i = 0; i < 4; i++)
			send_hit(1'b1, 10'd7, 48'hFFFF_FFFF_0000 + i * 48'h0040_0000, 32'd0, 31'(9 - i),
				31'(i), i);
		send(CMD_EOE, '0);

		// overflow: more hits than the store holds
		drain();
		write_cfg(CFG_WINDOW, 32'd0);
		send_idle = 0;
		for (int i = 0; i < 70; i++)
			send_hit(1'b1, 10'($urandom_range(3)), 48'($urandom_range(3)), $urandom,
				31'($urandom_range(3)), 31'($urandom), $urandom);
		send(CMD_EOE, '0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 58 : 20) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 58 : 20) : 0;
			drain();
			case (ph)
				0: begin
					write_cfg(CFG_THRESH, 32'd1240);
					write_cfg(CFG_WINDOW, 32'd3000);
				end
				1: begin
					write_cfg(CFG_THRESH, 32'hFFFF_FFFF);
					write_cfg(CFG_WINDOW, 32'd500);
				end
				2: begin
					write_cfg(CFG_THRESH, 32'd100);
					write_cfg(CFG_WINDOW, 32'h00FF_FFFF);
				end
				default: begin
					write_cfg(CFG_THRESH, 32'd1000);
					write_cfg(CFG_WINDOW, 32'd6000);
				end
			endcase
			for (int ev = 0; ev < 5; ev++)
				random_event($urandom_range(1, 5), $urandom_range(1, 3));
		end
		recv_stall = 0;
		drain();
		$display("sent %0d hits in %0d events, checked %0d merged hits", hits_sent, sb.events,
			sb.clusters);
		$display("covered threshold edges, window edges, overflow, empty events and stalls");
		if (sb.errors == 0 && sb.exp_data.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
